>>> hdl/hps_pkg.sv
// Shared constants and types for the host power sequencer.
package hps_pkg;

    localparam int COUNT_BITS = 24;
    localparam int MODE_BITS  = 2;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [MODE_BITS-1:0]  t_mode;
    typedef logic [1:0]            t_reg_idx;

    localparam t_mode MODE_IDLE   = 2'd0;
    localparam t_mode MODE_WAIT   = 2'd1;
    localparam t_mode MODE_AWAKE  = 2'd2;
    localparam t_mode MODE_REBOOT = 2'd3;

    localparam t_reg_idx REG_ON_LIMIT     = 2'd0;
    localparam t_reg_idx REG_OFF_LIMIT    = 2'd1;
    localparam t_reg_idx REG_WAKE_LIMIT   = 2'd2;
    localparam t_reg_idx REG_REBOOT_LIMIT = 2'd3;

    localparam t_count CNT_MAX = '1;

    localparam t_count RST_ON_LIMIT     = t_count'(60);
    localparam t_count RST_OFF_LIMIT    = t_count'(3600);
    localparam t_count RST_WAKE_LIMIT   = t_count'(3600);
    localparam t_count RST_REBOOT_LIMIT = t_count'(30);

    function automatic t_count sat_inc(input t_count v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + t_count'(1);
    endfunction

endpackage

>>> hdl/host_power_sequencer.sv
// Host power sequencer: tick-driven four-mode supply controller with an APB register port.
// Each input beat is one tick carrying the host status line and a force-wake flag; each
// tick produces exactly one output beat with the supply enable, the host-on indication and
// the mode after that tick. A tick sits in an input register, its mode logic (three saturating
// increments and a few 24-bit compares) is combinational, and the result lands in an
// output register, so a tick can be accepted on every clock unless the input stalls: the
// pipeline takes one beat per cycle while it is not stalled. The input stalls only when
// the input register is full and the output register is full and stalled downstream. The
// four limits (on, off, wake, reboot) sit at byte addresses 0, 4, 8 and 12; they may only be
// written while no tick is in flight. After reset the block waits for the host status with
// the supply enabled.
module host_power_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Tick input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_status_pin,
    input  logic                          i_force_wake,
    // Result output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_supply_enable,
    output logic                          o_host_on,
    output logic [hps_pkg::MODE_BITS-1:0] o_mode_now,
    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hps_pkg::ADDR_BITS-1:0] paddr,
    input  logic [hps_pkg::DATA_BITS-1:0] pwdata,
    output logic [hps_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import hps_pkg::*;

    // Configuration registers.
    t_count r_on_limit, r_off_limit, r_wake_limit, r_reboot_limit;

    // Sequencer state.
    t_mode  r_mode,       n_mode;
    t_count r_on_count,   n_on_count;
    t_count r_off_count,  n_off_count;
    t_count r_reboot_count, n_reboot_count;
    logic   r_supply_on,  n_supply_on;
    logic   r_awake_flag, n_awake_flag;

    // Input register.
    logic   r_in_valid;
    logic   r_status;
    logic   r_force;

    // Output register.
    logic   r_out_valid;
    logic   r_out_supply;
    logic   r_out_host_on;
    t_mode  r_out_mode;

    logic     out_adv;
    logic     tick_go;
    logic     in_take;
    logic     cfg_wr;
    t_reg_idx cfg_idx;
    t_count   inc_on, inc_off, inc_reboot;

    // The output stage can take a new result when it is empty or being drained this cycle.
    assign out_adv  = !r_out_valid || !i_out_stall;
    // The tick in the input register is processed when the result has somewhere to go.
    assign tick_go  = r_in_valid && out_adv;
    assign o_in_stall = r_in_valid && !out_adv;
    assign in_take  = i_in_valid && !o_in_stall;

    assign o_out_valid     = r_out_valid;
    assign o_supply_enable = r_out_supply;
    assign o_host_on       = r_out_host_on;
    assign o_mode_now      = r_out_mode;

    // ---------------------------------------------------------------------
    // Register port. The low two address bits are ignored.
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_ON_LIMIT:     prdata = DATA_BITS'(r_on_limit);
            REG_OFF_LIMIT:    prdata = DATA_BITS'(r_off_limit);
            REG_WAKE_LIMIT:   prdata = DATA_BITS'(r_wake_limit);
            REG_REBOOT_LIMIT: prdata = DATA_BITS'(r_reboot_limit);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_limit     <= RST_ON_LIMIT;
            r_off_limit    <= RST_OFF_LIMIT;
            r_wake_limit   <= RST_WAKE_LIMIT;
            r_reboot_limit <= RST_REBOOT_LIMIT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ON_LIMIT:     r_on_limit     <= pwdata[COUNT_BITS-1:0];
                REG_OFF_LIMIT:    r_off_limit    <= pwdata[COUNT_BITS-1:0];
                REG_WAKE_LIMIT:   r_wake_limit   <= pwdata[COUNT_BITS-1:0];
                REG_REBOOT_LIMIT: r_reboot_limit <= pwdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Mode logic for one tick. Every counter saturates at all ones.
    // ---------------------------------------------------------------------
    assign inc_on     = sat_inc(r_on_count);
    assign inc_off    = sat_inc(r_off_count);
    assign inc_reboot = sat_inc(r_reboot_count);

    always_comb begin
        n_mode         = r_mode;
        n_on_count     = r_on_count;
        n_off_count    = r_off_count;
        n_reboot_count = r_reboot_count;
        n_supply_on    = r_supply_on;
        n_awake_flag   = r_awake_flag;
        case (r_mode)
            MODE_IDLE: begin
                // Off period: ends at either limit or on a forced wake.
                n_off_count = inc_off;
                if (inc_off >= r_off_limit || inc_off >= r_wake_limit || r_force) begin
                    n_off_count = '0;
                    n_supply_on = 1'b1;
                    n_mode      = MODE_WAIT;
                end
            end
            MODE_WAIT: begin
                n_on_count = inc_on;
                if (r_status) begin
                    n_mode = MODE_AWAKE;
                end else if (inc_on >= r_on_limit) begin
                    n_supply_on = 1'b0;
                    n_on_count  = '0;
                    n_mode      = MODE_IDLE;
                end
            end
            MODE_AWAKE: begin
                n_awake_flag = 1'b1;
                if (!r_status) begin
                    // Status dropped: watch for a reboot.
                    n_reboot_count = '0;
                    n_on_count     = '0;
                    n_awake_flag   = 1'b0;
                    n_mode         = MODE_REBOOT;
                end else begin
                    n_on_count = inc_on;
                    if (inc_on >= r_on_limit) begin
                        n_supply_on  = 1'b0;
                        n_on_count   = '0;
                        n_awake_flag = 1'b0;
                        n_mode       = MODE_IDLE;
                    end
                end
            end
            default: begin
                // Reboot detection: after the wait, status decides reboot or shutdown.
                n_reboot_count = inc_reboot;
                if (inc_reboot >= r_reboot_limit) begin
                    n_reboot_count = '0;
                    if (r_status) begin
                        n_mode = MODE_AWAKE;
                    end else begin
                        n_supply_on = 1'b0;
                        n_mode      = MODE_IDLE;
                    end
                end
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Pipeline registers and state.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_mode         <= MODE_WAIT;
            r_on_count     <= '0;
            r_off_count    <= '0;
            r_reboot_count <= '0;
            r_supply_on    <= 1'b1;
            r_awake_flag   <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (tick_go) begin
                r_in_valid <= 1'b0;
            end
            if (tick_go) begin
                r_out_valid    <= 1'b1;
                r_mode         <= n_mode;
                r_on_count     <= n_on_count;
                r_off_count    <= n_off_count;
                r_reboot_count <= n_reboot_count;
                r_supply_on    <= n_supply_on;
                r_awake_flag   <= n_awake_flag;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_status <= i_status_pin;
            r_force  <= i_force_wake;
        end
        if (tick_go) begin
            r_out_supply  <= n_supply_on;
            r_out_host_on <= n_awake_flag;
            r_out_mode    <= n_mode;
        end
    end

`ifndef NO_ASSERTIONS
    // The supply is off exactly while the sequencer sits in the off period.
    a_supply_vs_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_supply_on == (r_mode != MODE_IDLE))
        else $error("supply enable out of step with idle mode");

    // The host-on flag can only be set while awake.
    a_awake_flag_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awake_flag |-> (r_mode == MODE_AWAKE))
        else $error("host-on flag set outside awake mode");

    // The off and reboot counters are cleared whenever their mode is left.
    a_off_count_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_off_count != '0) |-> (r_mode == MODE_IDLE))
        else $error("off counter running outside idle mode");

    a_reboot_count_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reboot_count != '0) |-> (r_mode == MODE_REBOOT))
        else $error("reboot counter running outside reboot detection");

    // The input side only stalls when a result is held back downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule
